### hdl/kat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types and constants for the keyed accumulate table.
// ----------------------------------------------------------------------------
package kat_pkg;

  localparam int unsigned FIELD_KEY_W = 16;
  localparam int unsigned VALUE_W     = 32;

  // Lookup miss result
  localparam logic signed [VALUE_W-1:0] RESULT_MISS = -32'sd1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_ACCUM  = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [FIELD_KEY_W-1:0]    key_row;
    logic [FIELD_KEY_W-1:0]    key_col;
    logic signed [VALUE_W-1:0] operand_value;
  } kat_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      found;
    logic                      table_full;
  } kat_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch item, register per-cell key match
    logic pick;     // select newest match, read its value
    logic apply;    // update table, load result register
  } kat_cmd_t;

endpackage

### hdl/keyed_accumulate_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_accumulate_table_top
// Bounded newest-first key/value table for sparse accumulation.
// ----------------------------------------------------------------------------
// Each transfer runs through compare, select and update steps: the accept
// edge compares the key against every cell in parallel, the next cycle picks
// the newest match and reads its value, and the update step rewrites the cell
// row (head insert, add in place, or compacting removal) and loads the result
// register. A new input transfer is accepted in the cycle after the update, so
// an item is taken only once the last is through; the update step waits only
// while the previous result is still stalled in the output register. Storage
// comes up empty after reset with no clearing pass.
module keyed_accumulate_table_top
  import kat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_BITS      = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kat_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kat_out_t out_data
);

  kat_cmd_t cmd;

  kat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  kat_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### hdl/kat_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_datapath
// Row of table cells with per-cell key compare, newest-match select,
// head insert shift, in-place add and compacting removal.
// ----------------------------------------------------------------------------
module kat_datapath
  import kat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_BITS      = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  kat_cmd_t cmd,
  input  kat_in_t  in_data,
  output kat_out_t out_data
);

  localparam int unsigned KW = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [KW-1:0]             row;
    logic [KW-1:0]             col;
    logic signed [VALUE_W-1:0] value;
  } ent_t;

  ent_t                      ent_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]  vld_r;
  logic [CW-1:0]             cnt_r;

  kind_t                     kind_r;
  logic [KW-1:0]             row_r;
  logic [KW-1:0]             col_r;
  logic signed [VALUE_W-1:0] opv_r;
  logic [TABLE_ENTRIES-1:0]  match_r;
  logic [TABLE_ENTRIES-1:0]  sel_r;
  logic                      hit_r;
  logic signed [VALUE_W-1:0] selv_r;
  kat_out_t                  out_r;

  logic [TABLE_ENTRIES-1:0]  match_nxt;
  logic [TABLE_ENTRIES-1:0]  sel_nxt;
  logic signed [VALUE_W-1:0] selv_nxt;
  logic [TABLE_ENTRIES-1:0]  below;
  logic                      full;
  logic signed [VALUE_W-1:0] sum;
  logic                      do_push;
  logic                      do_add;
  logic                      do_drop;
  kat_out_t                  out_nxt;
  ent_t                      new_ent;

  // Per-cell key compare against the incoming item
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_nxt[i] = vld_r[i] && (ent_r[i].row == in_data.key_row[KW-1:0])
                     && (ent_r[i].col == in_data.key_col[KW-1:0]);
    end
  end

  // Newest match is the lowest set bit; read its value
  assign sel_nxt = match_r & (~match_r + TABLE_ENTRIES'(1));

  always_comb begin
    selv_nxt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      selv_nxt = selv_nxt | (sel_nxt[i] ? ent_r[i].value : '0);
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_data.kind;
      row_r   <= in_data.key_row[KW-1:0];
      col_r   <= in_data.key_col[KW-1:0];
      opv_r   <= in_data.operand_value;
      match_r <= match_nxt;
    end
    if (cmd.pick) begin
      sel_r  <= sel_nxt;
      hit_r  <= |match_r;
      selv_r <= selv_nxt;
    end
    if (cmd.apply) begin
      out_r <= out_nxt;
    end
  end

  // Operation decode and result
  assign full    = (cnt_r == CW'(TABLE_ENTRIES));
  assign sum     = selv_r + opv_r;
  assign below   = sel_r - TABLE_ENTRIES'(1);
  assign new_ent = '{row: row_r, col: col_r, value: opv_r};

  always_comb begin
    do_push = 1'b0;
    do_add  = 1'b0;
    do_drop = 1'b0;
    out_nxt = '{result_value: '0, found: 1'b0, table_full: 1'b0};
    unique case (kind_r)
      KIND_INSERT: begin
        if (full) begin
          out_nxt.table_full = 1'b1;
        end else begin
          do_push              = 1'b1;
          out_nxt.result_value = opv_r;
        end
      end
      KIND_LOOKUP: begin
        if (hit_r) begin
          out_nxt.result_value = selv_r;
          out_nxt.found        = 1'b1;
        end else begin
          out_nxt.result_value = RESULT_MISS;
        end
      end
      KIND_ACCUM: begin
        if (hit_r) begin
          do_add               = 1'b1;
          out_nxt.result_value = sum;
          out_nxt.found        = 1'b1;
        end else if (full) begin
          out_nxt.table_full = 1'b1;
        end else begin
          do_push              = 1'b1;
          out_nxt.result_value = opv_r;
        end
      end
      KIND_REMOVE: begin
        if (hit_r) begin
          do_drop              = 1'b1;
          out_nxt.result_value = selv_r;
          out_nxt.found        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Table cells: shift down on push, add in place, shift up on removal
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ent_t from_prev;
    ent_t from_next;

    if (g == 0) begin : g_head
      assign from_prev = new_ent;
    end else begin : g_body
      assign from_prev = ent_r[g-1];
    end

    if (g == TABLE_ENTRIES - 1) begin : g_tail
      assign from_next = ent_r[g];
    end else begin : g_inner
      assign from_next = ent_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (do_push) begin
          ent_r[g] <= from_prev;
        end else if (do_add && sel_r[g]) begin
          ent_r[g].value <= sum;
        end else if (do_drop && !below[g]) begin
          ent_r[g] <= from_next;
        end
      end
    end
  end

  // Valid bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else if (cmd.apply) begin
      if (do_push) begin
        vld_r <= {vld_r[TABLE_ENTRIES-2:0], 1'b1};
        cnt_r <= cnt_r + CW'(1);
      end else if (do_drop) begin
        vld_r <= (vld_r & below) | ({1'b0, vld_r[TABLE_ENTRIES-1:1]} & ~below);
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // Valid bits always agree with the fill count
  a_cnt_vld: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_r) == 32'(cnt_r))
    else $error("valid bits disagree with fill count");

  // Occupied slots stay contiguous from the head
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r & (vld_r + TABLE_ENTRIES'(1))) == '0)
    else $error("occupied slots not contiguous");

  // A push always leaves an occupied head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && do_push |=> vld_r[0])
    else $error("head empty after insert");
`endif

endmodule

### hdl/kat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_ctrl
// Sequencer for one operation at a time and the result valid flag.
// ----------------------------------------------------------------------------
module kat_ctrl
  import kat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output kat_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_APPLY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // Result register can take a new value this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall    = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.pick    = (state_r == S_PICK);
  assign cmd.apply   = (state_r == S_APPLY) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // Never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // An accepted transfer moves on to the select step
  a_accept_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_PICK))
    else $error("accept did not start select step");

  // A new result appears only after an update step
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.apply))
    else $error("result valid without update");
`endif

endmodule

### tb/tb_keyed_accumulate_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_accumulate_table_top
// Self-checking bench for the newest-first keyed accumulate table.
// ----------------------------------------------------------------------------
// A shadow copy of the table predicts every result when an input transfer is
// accepted. Results are compared field by field in order. Directed items hit
// the corner cases first. Random traffic then runs in fill, mixed and drain
// phases so that the table goes full and empty again, with random idling on
// both sides.
module tb_keyed_accumulate_table_top
  import kat_pkg::*;
;

  // Shadow table plus the queue of results still owed by the block
  class kat_shadow;
    localparam int SLOTS = 64;

    logic [FIELD_KEY_W-1:0]    slot_row[SLOTS];
    logic [FIELD_KEY_W-1:0]    slot_col[SLOTS];
    logic signed [VALUE_W-1:0] slot_value[SLOTS];
    int unsigned               used;
    kat_out_t                  pending_results[$];
    int unsigned               fails;

    function new();
      used  = 0;
      fails = 0;
    endfunction

    // Slot of the newest entry with this key, -1 if none
    function int newest(logic [FIELD_KEY_W-1:0] r, logic [FIELD_KEY_W-1:0] c);
      for (int i = 0; i < used; i++)
        if (slot_row[i] == r && slot_col[i] == c) return i;
      return -1;
    endfunction

    function bit push_head(logic [FIELD_KEY_W-1:0] r, logic [FIELD_KEY_W-1:0] c,
                           logic signed [VALUE_W-1:0] v);
      if (used >= SLOTS) return 1'b0;
      for (int i = used; i > 0; i--) begin
        slot_row[i]   = slot_row[i-1];
        slot_col[i]   = slot_col[i-1];
        slot_value[i] = slot_value[i-1];
      end
      slot_row[0]   = r;
      slot_col[0]   = c;
      slot_value[0] = v;
      used++;
      return 1'b1;
    endfunction

    // Removal closes the gap by moving older entries up
    function void drop(int s);
      for (int i = s; i + 1 < used; i++) begin
        slot_row[i]   = slot_row[i+1];
        slot_col[i]   = slot_col[i+1];
        slot_value[i] = slot_value[i+1];
      end
      used--;
    endfunction

    // Apply one accepted transfer and queue the result it must produce
    function void note_transfer(kat_in_t t);
      kat_out_t exp_res;
      int       s;
      exp_res = '0;
      case (t.kind)
        KIND_INSERT: begin
          if (push_head(t.key_row, t.key_col, t.operand_value))
            exp_res.result_value = t.operand_value;
          else
            exp_res.table_full = 1'b1;
        end
        KIND_LOOKUP: begin
          s = newest(t.key_row, t.key_col);
          if (s >= 0) begin
            exp_res.result_value = slot_value[s];
            exp_res.found        = 1'b1;
          end else begin
            exp_res.result_value = RESULT_MISS;
          end
        end
        KIND_ACCUM: begin
          s = newest(t.key_row, t.key_col);
          if (s >= 0) begin
            slot_value[s]        = slot_value[s] + t.operand_value;
            exp_res.result_value = slot_value[s];
            exp_res.found        = 1'b1;
          end else if (push_head(t.key_row, t.key_col, t.operand_value)) begin
            exp_res.result_value = t.operand_value;
          end else begin
            exp_res.table_full = 1'b1;
          end
        end
        default: begin
          s = newest(t.key_row, t.key_col);
          if (s >= 0) begin
            exp_res.result_value = slot_value[s];
            exp_res.found        = 1'b1;
            drop(s);
          end
        end
      endcase
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(kat_out_t got);
      kat_out_t exp_res;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with nothing pending: value %0d found %0b full %0b",
                   $realtime, got.result_value, got.found, got.table_full);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.result_value !== exp_res.result_value || got.found !== exp_res.found ||
          got.table_full !== exp_res.table_full) begin
        fails++;
        if (fails <= 10)
          $display({"%0t: mismatch: exp value %0d found %0b full %0b,",
                    " got value %0d found %0b full %0b"},
                   $realtime, exp_res.result_value, exp_res.found, exp_res.table_full,
                   got.result_value, got.found, got.table_full);
      end
    endfunction
  endclass

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} phase_mode_t;

  localparam int PHASES          = 15;
  localparam int ITEMS_PER_PHASE = 104;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kat_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kat_out_t out_data;

  kat_shadow                 sb = new();
  bit                        calm = 1'b0;
  int unsigned               hold_left = 0;
  logic [FIELD_KEY_W-1:0]    pool_row[4];
  logic [FIELD_KEY_W-1:0]    pool_col[4];

  keyed_accumulate_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Input side monitor feeds the predictor
  always @(posedge clk) begin
    if (in_valid && in_stall === 1'b0) sb.note_transfer(in_data);
  end

  // Result side: check each transfer, then, unless calm, may stall before the next
  always @(posedge clk) begin : rx_side
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      sb.check_result(out_data);
      n = calm ? 0 : $urandom_range(0, 3);
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  function automatic kat_in_t mk(kind_t k, logic [15:0] r, logic [15:0] c,
                                 logic signed [31:0] v);
    kat_in_t t;
    t.kind          = k;
    t.key_row       = r;
    t.key_col       = c;
    t.operand_value = v;
    return t;
  endfunction

  function automatic kat_in_t random_item(phase_mode_t mode);
    kat_in_t     t;
    int unsigned roll;
    int unsigned pick;
    int unsigned slot;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  t.kind = roll < 65 ? KIND_INSERT : roll < 85 ? KIND_ACCUM :
                           roll < 95 ? KIND_LOOKUP : KIND_REMOVE;
      MODE_MIXED: t.kind = kind_t'(roll % 4);
      default:    t.kind = roll < 5 ? KIND_INSERT : roll < 10 ? KIND_ACCUM :
                           roll < 30 ? KIND_LOOKUP : KIND_REMOVE;
    endcase
    // Drain traffic mostly targets keys that are in the table right now
    pick = $urandom_range(0, 99);
    if (mode == MODE_DRAIN && t.kind != KIND_INSERT && sb.used != 0 && pick < 70) begin
      slot      = $urandom_range(0, sb.used - 1);
      t.key_row = sb.slot_row[slot];
      t.key_col = sb.slot_col[slot];
    end else if (pick < 88) begin
      t.key_row = pool_row[$urandom_range(0, 3)];
      t.key_col = pool_col[$urandom_range(0, 3)];
    end else begin
      t.key_row = FIELD_KEY_W'($urandom);
      t.key_col = FIELD_KEY_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       t.operand_value = 32'sh7fffffff;
      1:       t.operand_value = 32'sh80000000;
      2:       t.operand_value = -32'sd1;
      3:       t.operand_value = 32'sd1;
      default: t.operand_value = $urandom;
    endcase
    return t;
  endfunction

  // Hold valid across back-to-back transfers; only lower it for a real gap
  task automatic send_transfer(input kat_in_t item);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Main sequence
  initial begin
    pool_row[0] = 16'h0000;
    pool_row[1] = FIELD_KEY_W'($urandom);
    pool_row[2] = FIELD_KEY_W'($urandom);
    pool_row[3] = 16'hffff;
    pool_col[0] = 16'h0000;
    pool_col[1] = FIELD_KEY_W'($urandom);
    pool_col[2] = FIELD_KEY_W'($urandom);
    pool_col[3] = 16'hffff;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: misses on empty, extremes, wrap, shadowing, compaction
    send_transfer(mk(KIND_LOOKUP, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_INSERT, 16'h0000, 16'h0000, 32'sh7fffffff));
    send_transfer(mk(KIND_INSERT, 16'hffff, 16'hffff, 32'sh80000000));
    send_transfer(mk(KIND_LOOKUP, 16'hffff, 16'hffff, 32'sd9));
    send_transfer(mk(KIND_ACCUM,  16'h0000, 16'h0000, 32'sd1));
    send_transfer(mk(KIND_ACCUM,  16'h0000, 16'h0000, -32'sd1));
    send_transfer(mk(KIND_INSERT, 16'h0000, 16'h0000, 32'sd5));
    send_transfer(mk(KIND_LOOKUP, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_LOOKUP, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_ACCUM,  16'h0001, 16'h0002, -32'sd7));
    send_transfer(mk(KIND_ACCUM,  16'h0001, 16'h0002, 32'sh80000000));
    send_transfer(mk(KIND_LOOKUP, 16'hffff, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_LOOKUP, 16'h0000, 16'hffff, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'hffff, 16'hffff, 32'sd0));
    send_transfer(mk(KIND_LOOKUP, 16'h0001, 16'h0002, 32'sd0));
    send_transfer(mk(KIND_LOOKUP, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'h0000, 16'h0000, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'h0001, 16'h0002, 32'sd0));
    send_transfer(mk(KIND_REMOVE, 16'h0001, 16'h0002, 32'sd0));
    wait_settled();

    // Random: fill to full, churn, drain to empty, repeated
    for (int p = 0; p < PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_transfer(random_item(phase_mode_t'(p % 3)));
      wait_settled();
    end
    calm = 1'b0;

    repeat (12) @(posedge clk);
    if (sb.fails == 0 && sb.pending_results.size() == 0)
      $display("tb_keyed_accumulate_table_top: PASS");
    else
      $display("tb_keyed_accumulate_table_top: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_keyed_accumulate_table_top: FAIL");
    $finish;
  end

endmodule
